/* sv/wlss_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlss_pkg
// Shared sizes, codes and types of the wear-leveled settings store.
// ----------------------------------------------------------------------------
package wlss_pkg;

    localparam int WORDS       = 5;
    localparam int STORE_BYTES = 1024;
    localparam int SLOTS       = STORE_BYTES / (2 * WORDS + 1);

    localparam int WORD_IDX_W  = $clog2(WORDS);
    localparam int SLOT_W      = $clog2(SLOTS);
    localparam int REC_DEPTH   = SLOTS * WORDS;
    localparam int REC_AW      = $clog2(REC_DEPTH);

    typedef enum logic [1:0] {
        FN_LOAD    = 2'd0,
        FN_GET     = 2'd1,
        FN_SET_KEY = 2'd2,
        FN_SET_MOD = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_BAD_INDEX = 2'd1,
        ST_LOADED    = 2'd2,
        ST_NO_RECORD = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_INIT,
        S_SCAN_PREV,
        S_SCAN,
        S_LD_ADDR,
        S_LD_DATA,
        S_LD_CHECK,
        S_SET_APPLY,
        S_SAVE_WORD,
        S_SAVE_RING,
        S_DONE
    } state_t;

    typedef struct packed {
        logic capture;
        logic scan_init;
        logic scan_prev;
        logic scan_step;
        logic rec_cap;
        logic load_check;
        logic apply_set;
        logic rec_wr;
        logic ring_wr;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic  scan_done;
        logic  word_last;
        logic  idx_valid;
        func_t func;
    } sts_t;

    function automatic logic [15:0] reset_word(input int i);
        logic [15:0] w;
        case (i)
            0:       w = 16'h554B;
            1:       w = 16'h0001;
            2:       w = 16'h0056;
            3:       w = 16'h0057;
            4:       w = 16'h0067;
            default: w = 16'h0000;
        endcase
        return w;
    endfunction

endpackage

/* sv/wear_leveled_settings_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wear_leveled_settings_store
// Settings words backed by a wear-leveled record store with a status ring.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on s_valid/s_ready (s_func, s_reg_index, s_value); one
//   result per request leaves on m_valid/m_ready (m_keycode, m_modifiers,
//   m_status, m_slot_used). One request is in work at a time.
//   Every request first scans the status ring, one byte per cycle through
//   the ring's registered read port, up to the next write slot. Then a
//   get, or a set with a bad index, goes to the hand-off; a load reads and
//   captures each record word of the last-written slot, then checks it; a
//   set applies the value, writes each record word, then the ring byte.
//   The store holds 93 slots of 5 words.
//   After reset the settings words hold their defaults and the store reads
//   as erased (flip-flop valid bits, no clearing pass); the block is ready
//   as soon as reset is released.
//   A finished result sits in the output register while the next request is
//   accepted; if m_ready stays low, that request holds before its hand-off.
// ----------------------------------------------------------------------------
module wear_leveled_settings_store
    import wlss_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_func,
    input  logic [2:0] s_reg_index,
    input  logic [7:0] s_value,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_keycode,
    output logic [7:0] m_modifiers,
    output logic [1:0] m_status,
    output logic [6:0] m_slot_used
);

    cmd_t cmd;
    sts_t sts;

    wlss_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    wlss_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .s_func      (s_func),
        .s_reg_index (s_reg_index),
        .s_value     (s_value),
        .m_keycode   (m_keycode),
        .m_modifiers (m_modifiers),
        .m_status    (m_status),
        .m_slot_used (m_slot_used)
    );

    // one request at a time
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while busy");

    a_bad_index_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_BAD_INDEX) |-> (m_keycode == 8'd0) && (m_modifiers == 8'd0))
        else $error("bad index result carries binding bytes");

    // a result only appears at the end of a request in work
    a_result_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("result raised without a request in work");

    a_load_status: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load && sts.func == FN_LOAD |=>
            (m_status == ST_LOADED) || (m_status == ST_NO_RECORD))
        else $error("load reported a non-load status");

endmodule

/* sv/wlss_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlss_ctrl
// Sequencer: ring scan, record load or save, result hand-off.
// ----------------------------------------------------------------------------
module wlss_ctrl
    import wlss_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    output logic m_valid,
    input  logic m_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg, state_next;
    logic   m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) state_next = S_SCAN_INIT;
            end
            S_SCAN_INIT: state_next = S_SCAN_PREV;
            S_SCAN_PREV: state_next = S_SCAN;
            S_SCAN: begin
                if (sts.scan_done) begin
                    if (sts.func == FN_LOAD) begin
                        state_next = S_LD_ADDR;
                    end else if (!sts.idx_valid || sts.func == FN_GET) begin
                        state_next = S_DONE;
                    end else begin
                        state_next = S_SET_APPLY;
                    end
                end
            end
            S_LD_ADDR: state_next = S_LD_DATA;
            S_LD_DATA: begin
                state_next = sts.word_last ? S_LD_CHECK : S_LD_ADDR;
            end
            S_LD_CHECK:  state_next = S_DONE;
            S_SET_APPLY: state_next = S_SAVE_WORD;
            S_SAVE_WORD: begin
                if (sts.word_last) state_next = S_SAVE_RING;
            end
            S_SAVE_RING: state_next = S_DONE;
            S_DONE: begin
                if (!m_valid_reg || m_ready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            S_SCAN_INIT: cmd.scan_init  = 1'b1;
            S_SCAN_PREV: cmd.scan_prev  = 1'b1;
            S_SCAN:      cmd.scan_step  = 1'b1;
            S_LD_ADDR:   cmd            = '0;
            S_LD_DATA:   cmd.rec_cap    = 1'b1;
            S_LD_CHECK:  cmd.load_check = 1'b1;
            S_SET_APPLY: cmd.apply_set  = 1'b1;
            S_SAVE_WORD: cmd.rec_wr     = 1'b1;
            S_SAVE_RING: cmd.ring_wr    = 1'b1;
            S_DONE:      cmd.out_load   = !m_valid_reg || m_ready;
            default:     cmd            = '0;
        endcase
    end

    // output register: a new result may only replace one that was taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

/* sv/wlss_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlss_datapath
// Setting words, record store, status ring, scan logic and result register.
// ----------------------------------------------------------------------------
module wlss_datapath
    import wlss_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  cmd_t        cmd,
    output sts_t        sts,
    input  logic [1:0]  s_func,
    input  logic [2:0]  s_reg_index,
    input  logic [7:0]  s_value,
    output logic [7:0]  m_keycode,
    output logic [7:0]  m_modifiers,
    output logic [1:0]  m_status,
    output logic [6:0]  m_slot_used
);

    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS - 1);
    localparam logic [WORD_IDX_W-1:0] WORD_LAST = WORD_IDX_W'(WORDS - 1);
    localparam logic [REC_AW-1:0] REC_STRIDE = REC_AW'(WORDS);

    // request latch
    func_t       func_reg;
    logic [2:0]  reg_idx_reg;
    logic [7:0]  value_reg;

    logic [15:0] words_reg [WORDS];
    logic [15:0] rec_buf_reg [WORDS];
    logic [WORD_IDX_W-1:0] word_cnt_reg;

    // modeled nonvolatile store
    logic [15:0] rec_mem  [REC_DEPTH];
    logic [7:0]  ring_mem [SLOTS];
    logic [SLOTS-1:0] rec_valid_reg;
    logic [SLOTS-1:0] ring_valid_reg;

    logic [15:0] rec_rdata_reg;
    logic        rec_rvalid_reg;
    logic [7:0]  ring_rdata_reg;
    logic        ring_rvalid_reg;

    logic [SLOT_W-1:0] scan_idx_reg;
    logic [SLOT_W-1:0] nws_reg;
    logic [7:0]        prev_reg;
    logic              found_reg;

    logic [7:0]  m_keycode_reg;
    logic [7:0]  m_modifiers_reg;
    status_t     m_status_reg;
    logic [6:0]  m_slot_reg;

    logic              idx_valid;
    logic [WORD_IDX_W-1:0] word_sel;
    logic [7:0]        ring_val;
    logic [15:0]       rec_word;
    logic              scan_hit;
    logic              scan_last;
    logic [SLOT_W-1:0] ring_raddr;
    logic [SLOT_W-1:0] load_slot;
    logic [REC_AW-1:0] rec_raddr;
    logic [REC_AW-1:0] rec_waddr;
    logic              rec_match;
    logic [15:0]       out_word;
    status_t           out_status;
    logic [SLOT_W-1:0] out_slot;

    assign idx_valid = (reg_idx_reg >= 3'd2) && (reg_idx_reg <= 3'd4)
                       && (int'(reg_idx_reg) < WORDS);
    assign word_sel  = WORD_IDX_W'(reg_idx_reg);

    // entries never written read as erased
    assign ring_val  = ring_rvalid_reg ? ring_rdata_reg : 8'hFF;
    assign rec_word  = rec_rvalid_reg ? rec_rdata_reg : 16'hFFFF;

    assign scan_hit  = ring_val != (prev_reg + 8'd1);
    assign scan_last = scan_idx_reg == SLOT_LAST;
    assign load_slot = (nws_reg == '0) ? SLOT_LAST : nws_reg - 1'b1;
    assign rec_raddr = REC_AW'(load_slot) * REC_STRIDE + REC_AW'(word_cnt_reg);
    assign rec_waddr = REC_AW'(nws_reg) * REC_STRIDE + REC_AW'(word_cnt_reg);
    assign rec_match = (rec_buf_reg[0] == words_reg[0]) && (rec_buf_reg[1] == words_reg[1]);

    assign sts.scan_done = cmd.scan_step && (scan_hit || scan_last);
    assign sts.word_last = word_cnt_reg == WORD_LAST;
    assign sts.idx_valid = idx_valid;
    assign sts.func      = func_reg;

    // read-ahead: scan step fetches the following position
    always_comb begin
        ring_raddr = scan_idx_reg;
        if (cmd.scan_init) begin
            ring_raddr = SLOT_LAST;
        end else if (cmd.scan_step) begin
            ring_raddr = scan_last ? '0 : scan_idx_reg + 1'b1;
        end else if (cmd.ring_wr) begin
            ring_raddr = nws_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            func_reg    <= func_t'(s_func);
            reg_idx_reg <= s_reg_index;
            value_reg   <= s_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            word_cnt_reg <= '0;
        end else if ((cmd.rec_cap || cmd.rec_wr) && !sts.word_last) begin
            word_cnt_reg <= word_cnt_reg + 1'b1;
        end
    end

    // ring scan
    always_ff @(posedge aclk) begin
        if (cmd.scan_init) begin
            scan_idx_reg <= '0;
        end else if (cmd.scan_prev) begin
            prev_reg <= ring_val;
        end else if (cmd.scan_step) begin
            if (scan_hit) begin
                nws_reg <= scan_idx_reg;
            end else begin
                prev_reg <= ring_val;
                if (scan_last) begin
                    nws_reg <= '0;
                end else begin
                    scan_idx_reg <= scan_idx_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        ring_rdata_reg <= ring_mem[ring_raddr];
        if (cmd.ring_wr) begin
            ring_mem[nws_reg] <= prev_reg + 8'd1;
        end
    end

    always_ff @(posedge aclk) begin
        rec_rdata_reg <= rec_mem[rec_raddr];
        if (cmd.rec_wr) begin
            rec_mem[rec_waddr] <= words_reg[word_cnt_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ring_valid_reg  <= '0;
            rec_valid_reg   <= '0;
            ring_rvalid_reg <= 1'b0;
            rec_rvalid_reg  <= 1'b0;
        end else begin
            ring_rvalid_reg <= ring_valid_reg[ring_raddr];
            rec_rvalid_reg  <= rec_valid_reg[load_slot];
            if (cmd.ring_wr) ring_valid_reg[nws_reg] <= 1'b1;
            if (cmd.rec_wr)  rec_valid_reg[nws_reg]  <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rec_cap) begin
            rec_buf_reg[word_cnt_reg] <= rec_word;
        end
        if (cmd.load_check) begin
            found_reg <= rec_match;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WORDS; i++) begin
                words_reg[i] <= reset_word(i);
            end
        end else if (cmd.load_check && rec_match) begin
            for (int i = 0; i < WORDS; i++) begin
                words_reg[i] <= rec_buf_reg[i];
            end
        end else if (cmd.apply_set) begin
            if (func_reg == FN_SET_KEY) begin
                words_reg[word_sel][7:0] <= value_reg;
            end else begin
                words_reg[word_sel][15:8] <= value_reg;
            end
        end
    end

    always_comb begin
        out_word = idx_valid ? words_reg[word_sel] : 16'h0000;
        out_slot = nws_reg;
        if (func_reg == FN_LOAD) begin
            out_status = found_reg ? ST_LOADED : ST_NO_RECORD;
            out_slot   = load_slot;
        end else if (!idx_valid) begin
            out_status = ST_BAD_INDEX;
        end else begin
            out_status = ST_DONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_keycode_reg   <= out_word[7:0];
            m_modifiers_reg <= out_word[15:8];
            m_status_reg    <= out_status;
            m_slot_reg      <= 7'(out_slot);
        end
    end

    assign m_keycode   = m_keycode_reg;
    assign m_modifiers = m_modifiers_reg;
    assign m_status    = m_status_reg;
    assign m_slot_used = m_slot_reg;

endmodule

/* dv/wlss_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlss_checker
// Watches both channels of the wear-leveled settings store, keeps its own
// copy of the setting words, record slots and status ring, predicts the
// reply to every accepted request and compares each reply field by field.
// ----------------------------------------------------------------------------
module wlss_checker
    import wlss_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [1:0] s_func,
    input  logic [2:0] s_reg_index,
    input  logic [7:0] s_value,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [7:0] m_keycode,
    input  logic [7:0] m_modifiers,
    input  logic [1:0] m_status,
    input  logic [6:0] m_slot_used,
    output int         fail_count,
    output int         replies_pending
);

    typedef struct packed {
        logic [7:0] keycode;
        logic [7:0] modifiers;
        status_t    status;
        logic [6:0] slot;
    } binding_reply_t;

    localparam logic [15:0] BOOT_WORDS [5] = '{16'h554B, 16'h0001, 16'h0056,
                                               16'h0057, 16'h0067};

    logic [15:0]    words_q   [WORDS];
    logic [15:0]    rec_mem   [REC_DEPTH];
    logic [7:0]     wear_ring [SLOTS];
    binding_reply_t replies_due [$];
    binding_reply_t want;
    int             errors = 0;

    function automatic int ring_before(input int pos);
        return (pos == 0) ? SLOTS - 1 : pos - 1;
    endfunction

    // first ring position that does not continue its predecessor's count
    function automatic int next_free_slot();
        logic [7:0] succ;
        for (int i = 0; i < SLOTS; i++) begin
            succ = wear_ring[ring_before(i)] + 8'd1;
            if (succ != wear_ring[i])
                return i;
        end
        return 0;
    endfunction

    function automatic binding_reply_t process_request(input func_t fn,
                                                       input logic [2:0] idx,
                                                       input logic [7:0] val);
        binding_reply_t r;
        int             slot;
        int             base;
        logic           idx_ok;
        r      = '0;
        r.status = ST_DONE;
        idx_ok = (idx >= 3'd2) && (idx <= 3'd4) && (int'(idx) < WORDS);
        if (fn == FN_LOAD) begin
            slot = ring_before(next_free_slot());
            base = slot * WORDS;
            if (rec_mem[base] == words_q[0] && rec_mem[base + 1] == words_q[1]) begin
                for (int k = 0; k < WORDS; k++)
                    words_q[k] = rec_mem[base + k];
                r.status = ST_LOADED;
            end else begin
                r.status = ST_NO_RECORD;
            end
        end else if (!idx_ok) begin
            slot     = next_free_slot();
            r.status = ST_BAD_INDEX;
        end else if (fn == FN_GET) begin
            slot = next_free_slot();
        end else begin
            if (fn == FN_SET_KEY)
                words_q[idx][7:0] = val;
            else
                words_q[idx][15:8] = val;
            slot = next_free_slot();
            base = slot * WORDS;
            for (int k = 0; k < WORDS; k++)
                rec_mem[base + k] = words_q[k];
            wear_ring[slot] = wear_ring[ring_before(slot)] + 8'd1;
        end
        if (idx_ok) begin
            r.keycode   = words_q[idx][7:0];
            r.modifiers = words_q[idx][15:8];
        end
        r.slot = slot[6:0];
        return r;
    endfunction

    task automatic check_field(input string name, input logic [7:0] exp_val,
                               input logic [7:0] got_val);
        if (got_val !== exp_val) begin
            $error("%s: expected %0h, got %0h", name, exp_val, got_val);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WORDS; i++)
                words_q[i] = (i < 5) ? BOOT_WORDS[i] : 16'h0000;
            for (int i = 0; i < REC_DEPTH; i++)
                rec_mem[i] = 16'hFFFF;
            for (int i = 0; i < SLOTS; i++)
                wear_ring[i] = 8'hFF;
            replies_due.delete();
        end else begin
            if (s_valid && s_ready)
                replies_due.push_back(process_request(func_t'(s_func), s_reg_index,
                                                      s_value));
            if (m_valid && m_ready) begin
                if (replies_due.size() == 0) begin
                    $error("reply with no request outstanding");
                    errors++;
                end else begin
                    want = replies_due.pop_front();
                    check_field("m_keycode", want.keycode, m_keycode);
                    check_field("m_modifiers", want.modifiers, m_modifiers);
                    check_field("m_status", 8'(want.status), 8'(m_status));
                    check_field("m_slot_used", 8'(want.slot), 8'(m_slot_used));
                end
            end
        end
        fail_count      <= errors;
        replies_pending <= replies_due.size();
    end

endmodule

/* dv/wear_leveled_settings_store_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wear_leveled_settings_store_tb
// Drives directed and random load/get/set requests through several idle and
// stall phases; the checker predicts and compares every reply.
// ----------------------------------------------------------------------------
module wear_leveled_settings_store_tb;
    import wlss_pkg::*;

    localparam int RANDOM_ITEMS = 1600;
    localparam int PHASES       = 5;
    localparam int STUCK_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 120;

    // sender idle / receiver stall percentages per phase
    localparam int PHASE_IDLE  [PHASES] = '{0, 88, 0, 25, 0};
    localparam int PHASE_STALL [PHASES] = '{0, 0, 88, 25, 0};

    logic       aclk        = 1'b0;
    logic       aresetn     = 1'b0;
    logic       s_valid     = 1'b0;
    logic       s_ready;
    logic [1:0] s_func      = 2'd0;
    logic [2:0] s_reg_index = 3'd0;
    logic [7:0] s_value     = 8'd0;
    logic       m_valid;
    logic       m_ready     = 1'b0;
    logic [7:0] m_keycode;
    logic [7:0] m_modifiers;
    logic [1:0] m_status;
    logic [6:0] m_slot_used;

    int fail_count;
    int replies_pending;
    int idle_pct     = 0;
    int stall_pct    = 0;
    int stuck_cycles = 0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    wear_leveled_settings_store u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_func      (s_func),
        .s_reg_index (s_reg_index),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_keycode   (m_keycode),
        .m_modifiers (m_modifiers),
        .m_status    (m_status),
        .m_slot_used (m_slot_used)
    );

    wlss_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_reg_index     (s_reg_index),
        .s_value         (s_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_keycode       (m_keycode),
        .m_modifiers     (m_modifiers),
        .m_status        (m_status),
        .m_slot_used     (m_slot_used),
        .fail_count      (fail_count),
        .replies_pending (replies_pending)
    );

    always @(posedge aclk) begin
        if (!aresetn)
            m_ready <= 1'b0;
        else
            m_ready <= ($urandom_range(99) >= stall_pct);
    end

    // nothing accepted on either channel for too long: hang
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                stuck_cycles <= 0;
            else
                stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    task automatic send_req(input func_t fn, input logic [2:0] idx, input logic [7:0] val);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_func      <= fn;
        s_reg_index <= idx;
        s_value     <= val;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    // hold off new requests until every reply is back
    task automatic drain_replies();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (replies_pending != 0)
            @(posedge aclk);
    endtask

    initial begin
        func_t      fn;
        logic [2:0] idx;
        logic [7:0] val;
        int         pick;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // erased store: load finds nothing in the last slot
        send_req(FN_LOAD, 3'd0, 8'h00);
        for (int i = 0; i < 8; i++)
            send_req(FN_GET, 3'(i), 8'h00);
        send_req(FN_SET_KEY, 3'd2, 8'hFF);
        send_req(FN_SET_MOD, 3'd2, 8'h00);
        send_req(FN_SET_KEY, 3'd3, 8'h00);
        send_req(FN_SET_MOD, 3'd4, 8'hFF);
        // rejected sets leave the store alone
        send_req(FN_SET_KEY, 3'd7, 8'hAA);
        send_req(FN_SET_MOD, 3'd0, 8'h55);
        send_req(FN_SET_MOD, 3'd1, 8'hFF);
        send_req(FN_LOAD, 3'd3, 8'h00);
        // load with a bad index still loads, binding fields read zero
        send_req(FN_LOAD, 3'd6, 8'h00);
        send_req(FN_GET, 3'd4, 8'h00);
        send_req(FN_SET_KEY, 3'd4, 8'h5A);
        send_req(FN_GET, 3'd5, 8'h00);
        drain_replies();

        for (int p = 0; p < PHASES; p++) begin
            idle_pct  = PHASE_IDLE[p];
            stall_pct = PHASE_STALL[p];
            for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
                pick = $urandom_range(99);
                if (pick < 15)
                    fn = FN_LOAD;
                else if (pick < 40)
                    fn = FN_GET;
                else if (pick < 70)
                    fn = FN_SET_KEY;
                else
                    fn = FN_SET_MOD;
                if ($urandom_range(99) < 80)
                    idx = 3'($urandom_range(4, 2));
                else
                    idx = 3'($urandom_range(7));
                val = 8'($urandom_range(255));
                send_req(fn, idx, val);
            end
            drain_replies();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
